### sv/krb64_pkg.sv
// Package: types, constants and alphabet helpers for the keyed rotated base64 codec.
package krb64_pkg;

  localparam int unsigned ACC_W      = 14;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ROT_W      = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KEY_W      = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHAR  = CFG_IDX_W'(1);

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [KEY_W-1:0] KEY_RESET = 7'h41;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [7:0] POS_LO    = 8'd26;
  localparam logic [7:0] POS_DIG   = 8'd52;
  localparam logic [7:0] POS_PLUS  = 8'd62;
  localparam logic [7:0] POS_SLASH = 8'd63;
  localparam logic [6:0] POS_NONE  = 7'd64;

  typedef struct packed {
    logic [ACC_W-1:0] accum;
    logic [CNT_W-1:0] count;
    logic             started;
    logic             stopped;
    logic [ROT_W-1:0] rotation;
  } state_t;

  typedef struct packed {
    logic             direction;
    logic [KEY_W-1:0] key_char;
  } cfg_t;

  // The last result of an item always sits in val1.
  typedef struct packed {
    logic [1:0]        n;
    logic [BYTE_W-1:0] val0;
    logic [BYTE_W-1:0] val1;
  } result_t;

  function automatic logic [7:0] alpha_char(input logic [5:0] p);
    logic [7:0] pe;
    pe = {2'b00, p};
    if (pe < POS_LO) return CH_UP_A + pe;
    if (pe < POS_DIG) return CH_LO_A + (pe - POS_LO);
    if (pe < POS_PLUS) return CH_ZERO + (pe - POS_DIG);
    if (pe == POS_PLUS) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic logic [6:0] alpha_pos(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A;
      return d[6:0];
    end
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + POS_LO;
      return d[6:0];
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO + POS_DIG;
      return d[6:0];
    end
    if (c == CH_PLUS) return POS_PLUS[6:0];
    if (c == CH_SLASH) return POS_SLASH[6:0];
    return POS_NONE;
  endfunction

  function automatic logic [ACC_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    return (ACC_W'(1) << n) - ACC_W'(1);
  endfunction

endpackage

### sv/krb64_ifs.sv
// Interfaces: input, result and configuration channels of the codec.
interface krb64_in_if import krb64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              msg_end;

  modport source (output valid, output in_byte, output msg_end, input ready);
  modport sink (input valid, input in_byte, input msg_end, output ready);
endinterface

interface krb64_out_if import krb64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_value;
  logic              run_last;

  modport source (output valid, output out_value, output run_last, input ready);
  modport sink (input valid, input out_value, input run_last, output ready);
endinterface

interface krb64_cfg_if import krb64_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/krb64_step.sv
// Per-item step: encode or decode one beat against the current codec state.
module krb64_step import krb64_pkg::*; (
  input  state_t            st_i,
  input  cfg_t              cfg_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              sym_room_i,
  output state_t            st_o,
  output result_t           res_o,
  output logic              sym_used_o
);

  logic             key_first;
  logic [ROT_W-1:0] rot;
  logic [ACC_W-1:0] acc_e;
  logic [CNT_W-1:0] cnt_e;
  logic [1:0]       avail;
  logic [1:0]       nsym;
  logic [5:0]       s0;
  logic [5:0]       s1;
  logic [CNT_W-1:0] cnt_e_n;
  logic [7:0]       c0;
  logic [7:0]       c1;
  logic [7:0]       key_byte;

  logic [6:0]       pos;
  logic             stop;
  logic [5:0]       v_d;
  logic [ACC_W-1:0] acc_d;
  logic [CNT_W-1:0] cnt_d;
  logic [CNT_W-1:0] cnt_d_n;
  logic [7:0]       byte_d;

  assign key_first = !st_i.started;
  assign rot       = key_first ? cfg_i.key_char[ROT_W-1:0] : st_i.rotation;
  assign acc_e     = {st_i.accum[5:0], in_byte_i};
  assign cnt_e     = st_i.count + 4'd8;
  assign avail     = (cnt_e >= 4'd12) ? 2'd2 : ((cnt_e >= 4'd6) ? 2'd1 : 2'd0);
  assign nsym      = (key_first && avail == 2'd2) ? 2'd1 : avail;
  assign s0        = 6'(acc_e >> (cnt_e - 4'd6));
  assign s1        = 6'(acc_e >> (cnt_e - 4'd12));
  assign cnt_e_n   = cnt_e - ((nsym == 2'd2) ? 4'd12 : ((nsym == 2'd1) ? 4'd6 : 4'd0));
  assign c0        = alpha_char(s0 + rot);
  assign c1        = alpha_char(s1 + rot);
  assign key_byte  = {1'b0, cfg_i.key_char};

  assign pos     = alpha_pos(in_byte_i);
  assign stop    = (in_byte_i == CH_NL) || (in_byte_i == CH_NUL) || pos[6];
  assign v_d     = pos[5:0] - st_i.rotation;
  assign acc_d   = {st_i.accum[7:0], v_d};
  assign cnt_d   = st_i.count + 4'd6;
  assign cnt_d_n = cnt_d - 4'd8;
  assign byte_d  = 8'(acc_d >> cnt_d_n);

  always_comb begin
    st_o       = st_i;
    res_o      = '0;
    sym_used_o = 1'b0;
    if (cfg_i.direction == DIR_ENCODE) begin
      st_o.started  = 1'b1;
      st_o.rotation = rot;
      st_o.count    = cnt_e_n;
      st_o.accum    = acc_e & low_mask(cnt_e_n);
      if (key_first) begin
        res_o.n    = 2'd1 + nsym;
        res_o.val0 = key_byte;
        res_o.val1 = (nsym != 2'd0) ? c0 : key_byte;
      end else begin
        res_o.n    = nsym;
        res_o.val0 = c0;
        res_o.val1 = (nsym == 2'd2) ? c1 : c0;
      end
    end else if (key_first) begin
      st_o.started  = 1'b1;
      st_o.rotation = in_byte_i[ROT_W-1:0];
    end else if (!st_i.stopped && sym_room_i) begin
      sym_used_o = 1'b1;
      if (stop) begin
        st_o.stopped = 1'b1;
      end else if (cnt_d >= 4'd8) begin
        st_o.count = cnt_d_n;
        st_o.accum = acc_d & low_mask(cnt_d_n);
        res_o.n    = 2'd1;
        res_o.val0 = byte_d;
        res_o.val1 = byte_d;
      end else begin
        st_o.count = cnt_d;
        st_o.accum = acc_d;
      end
    end
  end

endmodule

### sv/keyed_rotated_base64_codec_unit.sv
// Top level: keyed rotated base64 codec with config registers and result buffering.
// Path: beat results go into the result holder registers, then into the output register.
// Throughput: one beat per cycle while out_o is not stalled and the beat yields at most one
// result; with two, input waits while the single output register drains the two-entry holder.
// Reset: direction encode, key 'A', codec state and symbol count cleared, result holder empty.
module keyed_rotated_base64_codec_unit import krb64_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  krb64_in_if.sink    in_i,
  krb64_out_if.source out_o,
  krb64_cfg_if.sink   cfg_i
);

  localparam int unsigned SymCntW = $clog2(MAX_SYMBOLS + 1);

  logic             direction_q;
  logic [KEY_W-1:0] key_char_q;
  state_t           st_q;
  state_t           st_next;
  result_t          res;
  cfg_t             cfg;
  logic             sym_used;
  logic             sym_room;
  logic [SymCntW-1:0] sym_cnt_q;

  logic [1:0]        pend_q;
  logic [1:0]        pend_d;
  logic [BYTE_W-1:0] val0_q;
  logic [BYTE_W-1:0] val1_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_value_q;
  logic              out_last_q;
  logic              pop;
  logic              in_acc;

  assign cfg.direction = direction_q;
  assign cfg.key_char  = key_char_q;
  assign sym_room      = sym_cnt_q < SymCntW'(MAX_SYMBOLS);

  krb64_step u_step (
    .st_i       (st_q),
    .cfg_i      (cfg),
    .in_byte_i  (in_i.in_byte),
    .sym_room_i (sym_room),
    .st_o       (st_next),
    .res_o      (res),
    .sym_used_o (sym_used)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_ENCODE;
      key_char_q  <= KEY_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DIRECTION: direction_q <= cfg_i.data[0];
        REG_KEY_CHAR:  key_char_q  <= cfg_i.data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  assign pop        = (pend_q != 2'd0) && (!out_valid_q || out_o.ready);
  assign in_i.ready = (pend_q == 2'd0) || (pend_q == 2'd1 && pop);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && res.n != 2'd0) begin
      pend_d = res.n;
    end else if (pop) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      sym_cnt_q <= '0;
      pend_q    <= 2'd0;
    end else begin
      pend_q <= pend_d;
      if (in_acc) begin
        if (in_i.msg_end) begin
          st_q      <= '0;
          sym_cnt_q <= '0;
        end else begin
          st_q      <= st_next;
          sym_cnt_q <= sym_cnt_q + SymCntW'(sym_used);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res.n != 2'd0) begin
      val0_q <= res.val0;
      val1_q <= res.val1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_value_q <= (pend_q == 2'd2) ? val0_q : val1_q;
      out_last_q  <= (pend_q == 2'd1);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.run_last  = out_last_q;

  a_pend_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.n != 2'd0) |=> (pend_q == $past(res.n)))
    else $error("result holder not loaded with beat results");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (pend_q != 2'd2))
    else $error("input ready while two results pending");

  a_sym_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_cnt_q <= SymCntW'(MAX_SYMBOLS))
    else $error("symbol count beyond limit");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.count <= 4'd6) && !st_q.count[0])
    else $error("pending bit count out of range");

endmodule
